@@ hw/rtl/rtsp_pkg.sv @@
// Shared types and constants of the resistive touch sample processor.
package rtsp_pkg;

    localparam int unsigned RAW_W   = 12;
    localparam int unsigned PRESS_W = 16;
    localparam int unsigned PT_W    = 16;
    localparam int unsigned SCR_W   = 9;

    localparam logic [RAW_W-1:0]   FULL_SCALE = 12'd4095;
    localparam logic [PRESS_W-1:0] PRESS_MAX  = 16'hFFFF;
    localparam logic [PT_W-1:0]    NO_POINT   = 16'hFFFF;

    localparam logic [1:0] PHASE_RELEASED = 2'd0;
    localparam logic [1:0] PHASE_PRESSED  = 2'd1;
    localparam logic [1:0] PHASE_MOVING   = 2'd2;

    localparam logic [2:0] REG_THRESHOLD  = 3'd0;
    localparam logic [2:0] REG_CAL_X_LOW  = 3'd1;
    localparam logic [2:0] REG_CAL_X_HIGH = 3'd2;
    localparam logic [2:0] REG_CAL_Y_LOW  = 3'd3;
    localparam logic [2:0] REG_CAL_Y_HIGH = 3'd4;
    localparam logic [2:0] REG_SWAP       = 3'd5;
    localparam logic [2:0] REG_MIRROR_X   = 3'd6;
    localparam logic [2:0] REG_MIRROR_Y   = 3'd7;

    // One classified sample as it waits in the queue.
    typedef struct packed {
        logic             touch;
        logic [PRESS_W-1:0] pressure;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
    } sample_t;

    typedef struct packed {
        logic [PRESS_W-1:0] threshold;
        logic [RAW_W-1:0]   x_low;
        logic [RAW_W-1:0]   x_high;
        logic [RAW_W-1:0]   y_low;
        logic [RAW_W-1:0]   y_high;
        logic               swap;
        logic               mirror_x;
        logic               mirror_y;
    } cfg_t;

endpackage

@@ hw/rtl/rtsp_divider.sv @@
// Restoring serial divider, one quotient bit per cycle.
module rtsp_divider #(
    parameter int unsigned N_W = 24,
    parameter int unsigned D_W = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] numer,
    input  logic [D_W-1:0] denom,
    output logic           done,
    output logic [N_W-1:0] quot
);
    localparam int unsigned CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   q_reg, q_next;
    logic [D_W:0]     r_reg, r_next;
    logic [D_W-1:0]   d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [D_W:0]     trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[D_W-1:0], q_reg[N_W-1]};
        if (start)
        begin
            q_next    = numer;
            r_next    = '0;
            d_next    = denom;
            cnt_next  = CNT_W'(N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

@@ hw/rtl/rtsp_front.sv @@
// Front end: takes samples, works out pressure and qualifies the touch.
module rtsp_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [48:0]             s_tdata,
    input  logic [15:0]             threshold,
    output logic                    q_valid,
    input  logic                    q_ready,
    output rtsp_pkg::sample_t       q_data
);
    import rtsp_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t     st_reg, st_next;
    sample_t     smp_reg, smp_next;
    logic        div_start;
    logic        div_done;
    logic [23:0] div_q;
    logic [RAW_W-1:0] z1, z2;
    logic        pen;
    logic [PRESS_W-1:0] press;

    assign pen = s_tdata[0];
    assign z1  = s_tdata[36:25];
    assign z2  = s_tdata[48:37];
    assign press = (div_q > 24'(PRESS_MAX)) ? PRESS_MAX : div_q[PRESS_W-1:0];

    rtsp_divider #(.N_W(24), .D_W(RAW_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (24'(z1) * 24'(FULL_SCALE)),
        .denom (z2 - z1),
        .done  (div_done),
        .quot  (div_q)
    );

    always_comb
    begin
        st_next   = st_reg;
        smp_next  = smp_reg;
        div_start = 1'b0;
        unique case (st_reg)
            F_IDLE:
            begin
                if (s_tvalid)
                begin
                    smp_next.raw_x    = s_tdata[12:1];
                    smp_next.raw_y    = s_tdata[24:13];
                    smp_next.pressure = '0;
                    smp_next.touch    = 1'b0;
                    if (!pen)
                    begin
                        smp_next.raw_x = '0;
                        smp_next.raw_y = '0;
                        st_next = F_PUSH;
                    end
                    else if (z2 > z1 && z1 != '0)
                    begin
                        div_start = 1'b1;
                        st_next   = F_DIV;
                    end
                    else
                    begin
                        smp_next.touch = (threshold == '0);
                        st_next = F_PUSH;
                    end
                end
            end
            F_DIV:
            begin
                if (div_done)
                begin
                    smp_next.pressure = press;
                    smp_next.touch    = (press >= threshold);
                    st_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (q_ready)
                    st_next = F_IDLE;
            end
            default: st_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= F_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
    end

    assign s_tready = (st_reg == F_IDLE);
    assign q_valid  = (st_reg == F_PUSH);
    assign q_data   = smp_reg;

    a_nodiv_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == F_DIV) |-> !s_tready) else $error("accepted during division");
    a_done_push: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == F_DIV && div_done) |=> q_valid) else $error("division result lost");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !q_ready) |=> (q_valid && $stable(q_data))) else $error("queue entry moved");
endmodule

@@ hw/rtl/rtsp_queue.sv @@
// Two-entry queue between front end and back end.
module rtsp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rtsp_pkg::sample_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rtsp_pkg::sample_t out_data
);
    import rtsp_pkg::*;

    sample_t    mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;
    assign out_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= in_data;
    end
endmodule

@@ hw/rtl/rtsp_back.sv @@
// Back end: calibration mapping, orientation, smoothing and result register.
module rtsp_back #(
    parameter int unsigned DISPLAY_WIDTH  = 320,
    parameter int unsigned DISPLAY_HEIGHT = 480,
    parameter int unsigned JUMP_LIMIT     = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  rtsp_pkg::sample_t q_data,
    input  rtsp_pkg::cfg_t    cfg,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata
);
    import rtsp_pkg::*;

    localparam logic [12:0] TOP_X = 13'(DISPLAY_WIDTH - 1);
    localparam logic [12:0] TOP_Y = 13'(DISPLAY_HEIGHT - 1);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_DX   = 5'b00010,
        B_DY   = 5'b00100,
        B_SMTH = 5'b01000,
        B_OUT  = 5'b10000
    } bstate_t;

    bstate_t     st_reg, st_next;
    sample_t     smp_reg;
    logic [12:0] mx_reg, my_reg;
    logic [PT_W-1:0] sx_reg, sy_reg;
    logic        was_reg;
    logic [63:0] res_reg;
    logic        dstart;
    logic        ddone;
    logic [23:0] dq;
    logic        ysel;
    logic [RAW_W-1:0] v, lo, hi, vc, num_v, den_v;
    logic [12:0] top;
    logic [12:0] x, y, ew, eh, t;
    logic [PT_W-1:0] nx, ny, dxa, dya, fx, fy;
    logic [17:0] mixx, mixy;

    assign ysel = (st_reg == B_DX);
    assign v    = ysel ? q_data.raw_y : q_data.raw_x;
    assign lo   = ysel ? cfg.y_low  : cfg.x_low;
    assign hi   = ysel ? cfg.y_high : cfg.x_high;
    assign top  = ysel ? TOP_Y : TOP_X;
    always_comb
    begin
        vc = v;
        if (vc < lo) vc = lo;
        if (vc > hi) vc = hi;
    end
    assign num_v = vc - lo;
    assign den_v = hi - lo;

    // The raw sample for the Y pass still sits at the head of the queue.
    rtsp_divider #(.N_W(24), .D_W(RAW_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .numer (24'(num_v) * 24'(top)),
        .denom (den_v),
        .done  (ddone),
        .quot  (dq)
    );

    always_comb
    begin
        x  = mx_reg;
        y  = my_reg;
        ew = 13'(DISPLAY_WIDTH);
        eh = 13'(DISPLAY_HEIGHT);
        if (cfg.swap)
        begin
            t = x; x = y; y = t;
            ew = 13'(DISPLAY_HEIGHT);
            eh = 13'(DISPLAY_WIDTH);
        end
        else
            t = '0;
        if (cfg.mirror_x) x = (x < ew) ? (ew - 13'd1 - x) : 13'd0;
        if (cfg.mirror_y) y = (y < eh) ? (eh - 13'd1 - y) : 13'd0;
        if (x >= ew) x = ew - 13'd1;
        if (y >= eh) y = eh - 13'd1;
        nx   = PT_W'(x);
        ny   = PT_W'(y);
        dxa  = (nx > sx_reg) ? nx - sx_reg : sx_reg - nx;
        dya  = (ny > sy_reg) ? ny - sy_reg : sy_reg - ny;
        mixx = 18'(sx_reg) * 18'd3 + 18'(nx);
        mixy = 18'(sy_reg) * 18'd3 + 18'(ny);
        if (sx_reg == NO_POINT || sy_reg == NO_POINT
            || dxa > PT_W'(JUMP_LIMIT) || dya > PT_W'(JUMP_LIMIT))
        begin
            fx = nx;
            fy = ny;
        end
        else
        begin
            fx = mixx[17:2];
            fy = mixy[17:2];
        end
    end

    always_comb
    begin
        st_next = st_reg;
        dstart  = 1'b0;
        unique case (st_reg)
            B_IDLE:
                if (q_valid && !m_tvalid)
                begin
                    if (q_data.touch)
                    begin
                        dstart  = 1'b1;
                        st_next = B_DX;
                    end
                    else
                        st_next = B_OUT;
                end
            B_DX:
                if (ddone)
                begin
                    dstart  = 1'b1;
                    st_next = B_DY;
                end
            B_DY:   if (ddone) st_next = B_SMTH;
            B_SMTH: st_next = B_OUT;
            B_OUT:  st_next = B_IDLE;
            default: st_next = B_IDLE;
        endcase
    end

    assign q_ready = (st_reg == B_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= B_IDLE;
            sx_reg   <= NO_POINT;
            sy_reg   <= NO_POINT;
            was_reg  <= 1'b0;
            m_tvalid <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            if (st_reg == B_SMTH)
            begin
                sx_reg <= fx;
                sy_reg <= fy;
            end
            if (st_reg == B_OUT)
            begin
                m_tvalid <= 1'b1;
                was_reg  <= smp_reg.touch;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == B_IDLE) smp_reg <= q_data;
        if (st_reg == B_IDLE) begin mx_reg <= '0; my_reg <= '0; end
        if (st_reg == B_DX && ddone)
            mx_reg <= (cfg.x_high == cfg.x_low) ? 13'd0 : dq[12:0];
        if (st_reg == B_DY && ddone)
            my_reg <= (cfg.y_high == cfg.y_low) ? 13'd0 : dq[12:0];
        if (st_reg == B_OUT)
        begin
            if (smp_reg.touch)
                res_reg <= {3'd0, smp_reg.raw_y, smp_reg.raw_x, smp_reg.pressure,
                            sy_reg[SCR_W-1:0], sx_reg[SCR_W-1:0],
                            was_reg ? PHASE_MOVING : PHASE_PRESSED, 1'b1};
            else
                res_reg <= {3'd0, 24'd0, smp_reg.pressure, 18'd0, PHASE_RELEASED, 1'b0};
        end
    end

    assign m_tdata = res_reg;

    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == B_OUT) |-> !m_tvalid) else $error("result overwritten");
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> q_valid) else $error("pop of empty queue");
    a_rel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[2:1] == PHASE_RELEASED))
        else $error("released phase wrong");
endmodule

@@ hw/rtl/resistive_touch_sample_processor_top.sv @@
// Top level of the resistive touch sample processor.
// A touching sample passes through the front end, which runs a 24-step serial
// pressure division, and then the back end, which runs two 24-step serial
// divisions for the X and Y calibration mapping, smooths and registers the result.
// A pen-up sample skips both the pressure division and the mapping, and a weak
// press skips only the mapping.
// A two-entry queue lets the two halves overlap, so the sustained rate is set by the
// back end, which takes no new sample until its last result has been taken.
module resistive_touch_sample_processor_top #(
    parameter int unsigned DISPLAY_WIDTH  = 320,
    parameter int unsigned DISPLAY_HEIGHT = 480,
    parameter int unsigned JUMP_LIMIT     = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pen_down, adc_x, adc_y, adc_z1, adc_z2 from bit 0 up
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // touch_valid, touch_phase, screen_x, screen_y, touch_pressure,
    // echo_raw_x, echo_raw_y from bit 0 up
    output logic [63:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import rtsp_pkg::*;

    cfg_t    cfg_reg;
    logic    fq_valid, fq_ready, qb_valid, qb_ready;
    sample_t fq_data, qb_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= 16'd100;
            cfg_reg.x_low     <= 12'd200;
            cfg_reg.x_high    <= 12'd3900;
            cfg_reg.y_low     <= 12'd200;
            cfg_reg.y_high    <= 12'd3900;
            cfg_reg.swap      <= 1'b0;
            cfg_reg.mirror_x  <= 1'b0;
            cfg_reg.mirror_y  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:  cfg_reg.threshold <= cfg_data;
                REG_CAL_X_LOW:  cfg_reg.x_low     <= cfg_data[11:0];
                REG_CAL_X_HIGH: cfg_reg.x_high    <= cfg_data[11:0];
                REG_CAL_Y_LOW:  cfg_reg.y_low     <= cfg_data[11:0];
                REG_CAL_Y_HIGH: cfg_reg.y_high    <= cfg_data[11:0];
                REG_SWAP:       cfg_reg.swap      <= cfg_data[0];
                REG_MIRROR_X:   cfg_reg.mirror_x  <= cfg_data[0];
                REG_MIRROR_Y:   cfg_reg.mirror_y  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    rtsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata[48:0]),
        .threshold (cfg_reg.threshold),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    rtsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    rtsp_back #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
        .JUMP_LIMIT     (JUMP_LIMIT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_data   (qb_data),
        .cfg      (cfg_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule

@@ tb/rtsp_checker.sv @@
// Checker for the touch sample processor: predicts each result and compares it.
module rtsp_checker #(
    parameter int unsigned DISPLAY_WIDTH  = 320,
    parameter int unsigned DISPLAY_HEIGHT = 480,
    parameter int unsigned JUMP_LIMIT     = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          touch_count
);
    import rtsp_pkg::*;

    typedef struct packed {
        logic [11:0] raw_y;
        logic [11:0] raw_x;
        logic [15:0] pressure;
        logic [8:0]  scr_y;
        logic [8:0]  scr_x;
        logic [1:0]  phase;
        logic        valid;
    } point_t;

    cfg_t        cfg;
    logic        touching;
    logic [15:0] sm_x;
    logic [15:0] sm_y;
    point_t      expected_points[$];

    function automatic int map_axis(int v, int lo, int hi, int top);
        if (lo == hi)
            return 0;
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return ((v - lo) * top) / (hi - lo);
    endfunction

    function automatic int clamp_axis(int v, int dim);
        if (v < 0)
            return 0;
        if (v >= dim)
            return dim - 1;
        return v;
    endfunction

    task automatic predict_point(input logic [55:0] d);
        point_t p;
        int z1, z2, press, x, y, ew, eh, t, dx, dy;
        p = '0;
        z1 = int'(d[36:25]);
        z2 = int'(d[48:37]);
        press = 0;
        if (!d[0]) begin
            touching = 1'b0;
        end
        else begin
            if (z2 > z1 && z1 > 0) begin
                press = (4095 * z1) / (z2 - z1);
                if (press > 65535)
                    press = 65535;
            end
            p.pressure = 16'(press);
            if (press < int'(cfg.threshold)) begin
                touching = 1'b0;
            end
            else begin
                x = map_axis(int'(d[12:1]), int'(cfg.x_low), int'(cfg.x_high),
                             DISPLAY_WIDTH - 1);
                y = map_axis(int'(d[24:13]), int'(cfg.y_low), int'(cfg.y_high),
                             DISPLAY_HEIGHT - 1);
                ew = DISPLAY_WIDTH;
                eh = DISPLAY_HEIGHT;
                if (cfg.swap) begin
                    t = x; x = y; y = t;
                    ew = DISPLAY_HEIGHT;
                    eh = DISPLAY_WIDTH;
                end
                if (cfg.mirror_x)
                    x = (ew - 1) - x;
                if (cfg.mirror_y)
                    y = (eh - 1) - y;
                x = clamp_axis(x, ew);
                y = clamp_axis(y, eh);
                if (sm_x == NO_POINT || sm_y == NO_POINT) begin
                    sm_x = 16'(x);
                    sm_y = 16'(y);
                end
                else begin
                    dx = (x > int'(sm_x)) ? x - int'(sm_x) : int'(sm_x) - x;
                    dy = (y > int'(sm_y)) ? y - int'(sm_y) : int'(sm_y) - y;
                    if (dx > JUMP_LIMIT || dy > JUMP_LIMIT) begin
                        sm_x = 16'(x);
                        sm_y = 16'(y);
                    end
                    else begin
                        sm_x = 16'((int'(sm_x) * 3 + x) / 4);
                        sm_y = 16'((int'(sm_y) * 3 + y) / 4);
                    end
                end
                p.valid = 1'b1;
                p.phase = touching ? PHASE_MOVING : PHASE_PRESSED;
                p.scr_x = sm_x[8:0];
                p.scr_y = sm_y[8:0];
                p.raw_x = d[12:1];
                p.raw_y = d[24:13];
                touching = 1'b1;
                touch_count++;
            end
        end
        expected_points.push_back(p);
    endtask

    task automatic compare_point(input logic [63:0] d);
        point_t e, a;
        a = d[60:0];
        if (expected_points.size() == 0) begin
            $error("result transfer with no expected point: %h", d);
            fail_count++;
        end
        else begin
            e = expected_points.pop_front();
            if (a.valid !== e.valid) begin
                $error("touch_valid: expected %0d, actual %0d", e.valid, a.valid);
                fail_count++;
            end
            if (a.phase !== e.phase) begin
                $error("touch_phase: expected %0d, actual %0d", e.phase, a.phase);
                fail_count++;
            end
            if (a.scr_x !== e.scr_x) begin
                $error("screen_x: expected %0d, actual %0d", e.scr_x, a.scr_x);
                fail_count++;
            end
            if (a.scr_y !== e.scr_y) begin
                $error("screen_y: expected %0d, actual %0d", e.scr_y, a.scr_y);
                fail_count++;
            end
            if (a.pressure !== e.pressure) begin
                $error("touch_pressure: expected %0d, actual %0d", e.pressure, a.pressure);
                fail_count++;
            end
            if (a.raw_x !== e.raw_x) begin
                $error("echo_raw_x: expected %0d, actual %0d", e.raw_x, a.raw_x);
                fail_count++;
            end
            if (a.raw_y !== e.raw_y) begin
                $error("echo_raw_y: expected %0d, actual %0d", e.raw_y, a.raw_y);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg <= '{threshold: 16'd100, x_low: 12'd200, x_high: 12'd3900,
                     y_low: 12'd200, y_high: 12'd3900, swap: 1'b0,
                     mirror_x: 1'b0, mirror_y: 1'b0};
            touching = 1'b0;
            sm_x = NO_POINT;
            sm_y = NO_POINT;
            expected_points.delete();
            fail_count <= 0;
            pending <= 0;
            touch_count = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_THRESHOLD:  cfg.threshold <= cfg_data;
                    REG_CAL_X_LOW:  cfg.x_low <= cfg_data[11:0];
                    REG_CAL_X_HIGH: cfg.x_high <= cfg_data[11:0];
                    REG_CAL_Y_LOW:  cfg.y_low <= cfg_data[11:0];
                    REG_CAL_Y_HIGH: cfg.y_high <= cfg_data[11:0];
                    REG_SWAP:       cfg.swap <= cfg_data[0];
                    REG_MIRROR_X:   cfg.mirror_x <= cfg_data[0];
                    REG_MIRROR_Y:   cfg.mirror_y <= cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
                compare_point(m_tdata);
            if (s_tvalid && s_tready)
                predict_point(s_tdata);
            pending <= expected_points.size();
        end
    end

endmodule

@@ tb/resistive_touch_sample_processor_top_tb.sv @@
// Stimulus and verdict for the touch sample processor testbench.
module resistive_touch_sample_processor_top_tb;
    import rtsp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    int          touch_count;
    int          sample_count;
    int          burst_left;
    logic [11:0] track_x;
    logic [11:0] track_y;

    resistive_touch_sample_processor_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    rtsp_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .touch_count(touch_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The receiver stalls on a pattern that changes between calm and busy stretches.
    always @(negedge clk)
    begin
        if ((sample_count / 200) % 3 == 0)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        #60000000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_sample(input logic pen, input logic [11:0] x, input logic [11:0] y,
                               input logic [11:0] z1, input logic [11:0] z2);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, z2, z1, y, x, pen};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        sample_count++;
    endtask

    task automatic settle;
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_sample;
        logic [11:0] z1, z2;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            send_sample(1'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                        12'($urandom));
        end
        else if (r == 1) begin
            send_sample(1'b0, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
        end
        else begin
            if ($urandom_range(0, 3) == 0) begin
                track_x = 12'($urandom);
                track_y = 12'($urandom);
            end
            else begin
                track_x = 12'(int'(track_x) + int'($urandom_range(0, 60)) - 30);
                track_y = 12'(int'(track_y) + int'($urandom_range(0, 60)) - 30);
            end
            z1 = 12'($urandom_range(1, 2000));
            z2 = 12'(int'(z1) + int'($urandom_range(1, 4095 - int'(z1))));
            send_sample(1'b1, track_x, track_y, z1, z2);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_THRESHOLD;
        cfg_data = '0;
        sample_count = 0;
        burst_left = 0;
        track_x = 12'd2000;
        track_y = 12'd2000;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: pen up, weak press, pressure saturation, field extremes.
        send_sample(1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_sample(1'b1, 12'd2000, 12'd2000, 12'd0, 12'd4095);
        send_sample(1'b1, 12'd2000, 12'd2000, 12'd4095, 12'd1);
        send_sample(1'b1, 12'd2000, 12'd2000, 12'd10, 12'd4095);
        send_sample(1'b1, 12'd0, 12'd0, 12'd4094, 12'd4095);
        send_sample(1'b1, 12'd4095, 12'd4095, 12'd2000, 12'd2001);
        send_sample(1'b1, 12'd4093, 12'd4090, 12'd2000, 12'd2100);
        send_sample(1'b1, 12'd4090, 12'd4094, 12'd2000, 12'd2100);
        send_sample(1'b1, 12'd2000, 12'd2000, 12'd1000, 12'd1000);
        send_sample(1'b1, 12'd1234, 12'd3210, 12'd1, 12'd2);
        send_sample(1'b1, 12'd1240, 12'd3200, 12'd1, 12'd2);

        for (int phase_i = 0; phase_i < 7; phase_i++) begin
            settle();
            case (phase_i)
                0: begin
                    write_reg(REG_THRESHOLD, 16'd0);
                    write_reg(REG_CAL_X_LOW, 16'd0);
                    write_reg(REG_CAL_X_HIGH, 16'd4095);
                    write_reg(REG_CAL_Y_LOW, 16'd0);
                    write_reg(REG_CAL_Y_HIGH, 16'd4095);
                    write_reg(REG_SWAP, 16'd1);
                end
                1: begin
                    write_reg(REG_MIRROR_X, 16'd1);
                    write_reg(REG_MIRROR_Y, 16'd1);
                    write_reg(REG_THRESHOLD, 16'hFFFF);
                end
                2: begin
                    write_reg(REG_THRESHOLD, 16'd500);
                    write_reg(REG_CAL_X_LOW, 16'd3000);
                    write_reg(REG_CAL_X_HIGH, 16'd1000);
                    write_reg(REG_CAL_Y_LOW, 16'd2222);
                    write_reg(REG_CAL_Y_HIGH, 16'd2222);
                    write_reg(REG_SWAP, 16'd0);
                end
                3: begin
                    write_reg(REG_CAL_X_LOW, 16'd4095);
                    write_reg(REG_CAL_X_HIGH, 16'd0);
                    write_reg(REG_CAL_Y_LOW, 16'd4095);
                    write_reg(REG_CAL_Y_HIGH, 16'd4095);
                    write_reg(REG_MIRROR_Y, 16'd0);
                end
                4: begin
                    write_reg(REG_THRESHOLD, 16'd100);
                    write_reg(REG_CAL_X_LOW, 16'd300);
                    write_reg(REG_CAL_X_HIGH, 16'd3800);
                    write_reg(REG_CAL_Y_LOW, 16'd150);
                    write_reg(REG_CAL_Y_HIGH, 16'd3950);
                    write_reg(REG_MIRROR_X, 16'd0);
                    write_reg(REG_MIRROR_Y, 16'd1);
                end
                5: begin
                    write_reg(REG_SWAP, 16'd1);
                    write_reg(REG_MIRROR_X, 16'd1);
                    write_reg(REG_THRESHOLD, 16'd3000);
                end
                default: begin
                    write_reg(REG_THRESHOLD, 16'd1);
                    write_reg(REG_CAL_X_LOW, 16'd0);
                    write_reg(REG_CAL_X_HIGH, 16'd1);
                    write_reg(REG_CAL_Y_LOW, 16'd4094);
                    write_reg(REG_CAL_Y_HIGH, 16'd4095);
                    write_reg(REG_SWAP, 16'd0);
                    write_reg(REG_MIRROR_X, 16'd0);
                    write_reg(REG_MIRROR_Y, 16'd0);
                end
            endcase
            for (int k = 0; k < 220; k++)
                random_sample();
        end

        settle();
        $display("Covered %0d samples under eight register settings, %0d of them touches.",
                 sample_count, touch_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/rtsp_pkg.sv
hw/rtl/rtsp_divider.sv
hw/rtl/rtsp_front.sv
hw/rtl/rtsp_queue.sv
hw/rtl/rtsp_back.sv
hw/rtl/resistive_touch_sample_processor_top.sv
tb/rtsp_checker.sv
tb/resistive_touch_sample_processor_top_tb.sv
